### hdl/bmfl_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register codes, selection types and saturation for the field lookup core.
package bmfl_pkg;

  localparam int POS_W      = 16;
  localparam int Z_W        = 21;
  localparam int FIELD_W    = 22;
  localparam int CFG_W      = 18;
  localparam int SCALE_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int SAT_IN_W   = 36;

  localparam logic [CFG_ADDR_W-1:0] REG_QUAD_GRADIENT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DIPOLE_STRENGTH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COMP_C2_FIELD   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COMP_A1_FIELD   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COMP_A2_FIELD   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DIPOLE_SCALE    = 3'd5;

  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd16384;

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = 36'sd2097151;
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -36'sd2097152;

  // Which magnet, if any, decides the field at the point.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_COMP,
    KIND_QUAD_POS,
    KIND_QUAD_NEG,
    KIND_DIP_POS,
    KIND_DIP_NEG
  } bmfl_kind_t;

  typedef struct packed {
    logic       side_a;
    logic       a1_hit;
    bmfl_kind_t kind;
  } bmfl_sel_t;

  typedef struct packed {
    logic signed [CFG_W-1:0]   quad_gradient;
    logic signed [CFG_W-1:0]   dipole_strength;
    logic signed [CFG_W-1:0]   comp_c2_field;
    logic signed [CFG_W-1:0]   comp_a1_field;
    logic signed [CFG_W-1:0]   comp_a2_field;
    logic signed [SCALE_W-1:0] dipole_scale;
  } bmfl_cfg_t;

  function automatic logic signed [FIELD_W-1:0] sat_field(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic signed [FIELD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[FIELD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[FIELD_W-1:0];
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/bmfl_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the field lookup core.
module bmfl_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bmfl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bmfl_pkg::CFG_W-1:0]       cfg_wdata,
  output bmfl_pkg::bmfl_cfg_t              cfg
);
  import bmfl_pkg::*;

  bmfl_cfg_t cfg_r;
  bmfl_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_QUAD_GRADIENT:   cfg_nxt.quad_gradient   = cfg_wdata;
        REG_DIPOLE_STRENGTH: cfg_nxt.dipole_strength = cfg_wdata;
        REG_COMP_C2_FIELD:   cfg_nxt.comp_c2_field   = cfg_wdata;
        REG_COMP_A1_FIELD:   cfg_nxt.comp_a1_field   = cfg_wdata;
        REG_COMP_A2_FIELD:   cfg_nxt.comp_a2_field   = cfg_wdata;
        REG_DIPOLE_SCALE:    cfg_nxt.dipole_scale    = cfg_wdata[SCALE_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quad_gradient   <= '0;
      cfg_r.dipole_strength <= '0;
      cfg_r.comp_c2_field   <= '0;
      cfg_r.comp_a1_field   <= '0;
      cfg_r.comp_a2_field   <= '0;
      cfg_r.dipole_scale    <= SCALE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/bmfl_region.sv
`timescale 1ns / 1ps
// Region decoder: picks the magnet that owns the point, in priority order per side.
module bmfl_region #(
  parameter int FRAC_BITS = 6
) (
  input  logic signed [bmfl_pkg::POS_W-1:0] pos_x,
  input  logic signed [bmfl_pkg::POS_W-1:0] pos_y,
  input  logic signed [bmfl_pkg::Z_W-1:0]   pos_z,
  output bmfl_pkg::bmfl_sel_t               sel
);
  import bmfl_pkg::*;

  localparam int ZW  = 25;
  localparam int ONE = 1 << FRAC_BITS;

  // Centres rounded half up to position units; tenths of a cm in the products.
  localparam int C_A1 = (10750 * ONE + 5) / 10;
  localparam int C_CP = (20490 * ONE + 5) / 10;
  localparam int C_Q1 = (26150 * ONE + 5) / 10;
  localparam int C_Q2 = (34800 * ONE + 5) / 10;
  localparam int C_Q3 = (41300 * ONE + 5) / 10;
  localparam int C_Q4 = (50150 * ONE + 5) / 10;
  localparam int C_D1 = (63108 * ONE + 5) / 10;
  localparam int C_D2 = (126403 * ONE + 5) / 10;

  localparam int H_A1 = 260 * ONE / 2;
  localparam int H_CP = 153 * ONE / 2;
  localparam int H_QL = 637 * ONE / 2;
  localparam int H_QS = 550 * ONE / 2;
  localparam int H_D  = 945 * ONE / 2;

  // Radii in eighths of a cm.
  localparam int R27 = 27 * ONE / 8;
  localparam int R28 = 28 * ONE / 8;
  localparam int R30 = 30 * ONE / 8;
  localparam int R32 = 32 * ONE / 8;
  localparam int R36 = 36 * ONE / 8;
  localparam logic [31:0] R2_27 = 32'(R27 * R27);
  localparam logic [31:0] R2_28 = 32'(R28 * R28);
  localparam logic [31:0] R2_30 = 32'(R30 * R30);
  localparam logic [31:0] R2_32 = 32'(R32 * R32);
  localparam logic [31:0] R2_36 = 32'(R36 * R36);

  localparam logic [POS_W-1:0] BORE_C = POS_W'((97 * ONE + 5) / 10);
  localparam logic [POS_W-1:0] BORE_A = POS_W'((94 * ONE + 5) / 10);

  function automatic logic z_in(input logic [ZW-1:0] az, input int c, input int h);
    logic [ZW-1:0] lo;
    logic [ZW-1:0] hi;
    lo = ZW'(c - h);
    hi = ZW'(c + h);
    return (az > lo) && (az < hi);
  endfunction

  logic                side_a;
  logic [Z_W-1:0]      az;
  logic [ZW-1:0]       az_w;
  logic signed [31:0]  xx;
  logic signed [31:0]  yy;
  logic [31:0]         rad2;
  logic [POS_W-1:0]    ax;
  logic [POS_W-1:0]    bore_off;
  logic [31:0]         bore_r2;
  logic signed [POS_W:0] dx;
  logic signed [33:0]  dxx;
  logic [31:0]         bore_d2;
  logic                in_bore;
  logic                r27, r28, r30, r32, r36;
  logic                z_a1, z_cp, z_q1, z_q2, z_q3, z_q4, z_d1, z_d2;

  assign side_a = !pos_z[Z_W-1];
  assign az     = pos_z[Z_W-1] ? Z_W'(-pos_z) : Z_W'(pos_z);
  assign az_w   = ZW'(az);

  assign xx   = pos_x * pos_x;
  assign yy   = pos_y * pos_y;
  assign rad2 = 32'(xx) + 32'(yy);

  assign r27 = rad2 < R2_27;
  assign r28 = rad2 < R2_28;
  assign r30 = rad2 < R2_30;
  assign r32 = rad2 < R2_32;
  assign r36 = rad2 < R2_36;

  // Second separation dipole: distance to the nearer offset bore.
  assign ax       = pos_x[POS_W-1] ? POS_W'(-pos_x) : POS_W'(pos_x);
  assign bore_off = side_a ? BORE_A : BORE_C;
  assign bore_r2  = side_a ? R2_30 : R2_36;
  assign dx       = $signed({1'b0, ax}) - $signed({1'b0, bore_off});
  assign dxx      = dx * dx;
  assign bore_d2  = 32'(dxx) + 32'(yy);
  assign in_bore  = bore_d2 < bore_r2;

  assign z_a1 = z_in(az_w, C_A1, H_A1);
  assign z_cp = z_in(az_w, C_CP, H_CP);
  assign z_q1 = z_in(az_w, C_Q1, H_QL);
  assign z_q2 = z_in(az_w, C_Q2, H_QS);
  assign z_q3 = z_in(az_w, C_Q3, H_QS);
  assign z_q4 = z_in(az_w, C_Q4, H_QL);
  assign z_d1 = z_in(az_w, C_D1, H_D);
  assign z_d2 = z_in(az_w, C_D2, H_D);

  always_comb begin
    sel.side_a = side_a;
    sel.a1_hit = side_a && z_a1 && r32;
    sel.kind   = KIND_NONE;
    if (!side_a) begin
      if (z_cp && r36) begin
        sel.kind = KIND_COMP;
      end else if (z_q1 && r28) begin
        sel.kind = KIND_QUAD_POS;
      end else if (z_q2 && r28) begin
        sel.kind = KIND_QUAD_NEG;
      end else if (z_q3 && r28) begin
        sel.kind = KIND_QUAD_NEG;
      end else if (z_q4 && r28) begin
        sel.kind = KIND_QUAD_POS;
      end else if (z_d1 && r36) begin
        sel.kind = KIND_DIP_POS;
      end else if (z_d2 && r36) begin
        sel.kind = in_bore ? KIND_DIP_NEG : KIND_NONE;
      end
    end else begin
      if (z_cp && r36) begin
        sel.kind = KIND_COMP;
      end else if (z_q1 && r28) begin
        sel.kind = KIND_QUAD_NEG;
      end else if (z_q2 && r28) begin
        sel.kind = KIND_QUAD_POS;
      end else if (z_q3 && r28) begin
        sel.kind = KIND_QUAD_POS;
      end else if (z_q4 && r28) begin
        sel.kind = KIND_QUAD_NEG;
      end else if (z_d1 && r27) begin
        sel.kind = KIND_DIP_NEG;
      end else if (z_d2 && r30) begin
        sel.kind = in_bore ? KIND_DIP_POS : KIND_NONE;
      end
    end
  end

endmodule

### hdl/bmfl_field.sv
`timescale 1ns / 1ps
// Field evaluator: compensator, quadrupole and dipole values with rounding and saturation.
module bmfl_field #(
  parameter int FRAC_BITS = 6
) (
  input  bmfl_pkg::bmfl_cfg_t                 cfg,
  input  bmfl_pkg::bmfl_sel_t                 sel,
  input  logic signed [bmfl_pkg::POS_W-1:0]   pos_x,
  input  logic signed [bmfl_pkg::POS_W-1:0]   pos_y,
  output logic signed [bmfl_pkg::FIELD_W-1:0] field_x,
  output logic signed [bmfl_pkg::FIELD_W-1:0] field_y
);
  import bmfl_pkg::*;

  localparam int PW = CFG_W + POS_W + 1;
  localparam int QW = PW - FRAC_BITS;
  localparam logic signed [PW-1:0] QUAD_HALF = PW'(1) << (FRAC_BITS - 1);
  localparam int CW = CFG_W + SCALE_W + 1;
  localparam int SCALE_FRAC = 14;
  localparam logic signed [CW-1:0] COMP_HALF = CW'(1) << (SCALE_FRAC - 1);

  logic signed [CFG_W-1:0]            comp_field;
  logic signed [CFG_W+SCALE_W-1:0]    comp_prod;
  logic signed [CW-1:0]               comp_sum;
  logic signed [CW-SCALE_FRAC-1:0]    comp_val;
  logic signed [FIELD_W-1:0]          comp_out;

  logic signed [CFG_W+POS_W-1:0]      gx;
  logic signed [CFG_W+POS_W-1:0]      gy;
  logic                               quad_neg;
  logic signed [PW-1:0]               gx_s;
  logic signed [PW-1:0]               gy_s;
  logic signed [PW-1:0]               gx_sum;
  logic signed [PW-1:0]               gy_sum;
  logic signed [QW-1:0]               qx;
  logic signed [QW-1:0]               qy;

  logic signed [CFG_W:0]              dp_pos;
  logic signed [CFG_W:0]              dp_neg;

  // Only one compensator value can win, so one multiplier serves all three.
  always_comb begin
    if (sel.kind == KIND_COMP) begin
      comp_field = sel.side_a ? cfg.comp_a2_field : cfg.comp_c2_field;
    end else begin
      comp_field = cfg.comp_a1_field;
    end
  end

  assign comp_prod = comp_field * cfg.dipole_scale;
  assign comp_sum  = CW'(comp_prod) + COMP_HALF;
  assign comp_val  = comp_sum[CW-1:SCALE_FRAC];
  assign comp_out  = sat_field(SAT_IN_W'(comp_val));

  // Negate before rounding so that the half-up rule sees the signed product.
  assign gx       = cfg.quad_gradient * pos_x;
  assign gy       = cfg.quad_gradient * pos_y;
  assign quad_neg = (sel.kind == KIND_QUAD_NEG);
  assign gx_s     = quad_neg ? -PW'(gx) : PW'(gx);
  assign gy_s     = quad_neg ? -PW'(gy) : PW'(gy);
  assign gx_sum   = gx_s + QUAD_HALF;
  assign gy_sum   = gy_s + QUAD_HALF;
  assign qx       = gx_sum[PW-1:FRAC_BITS];
  assign qy       = gy_sum[PW-1:FRAC_BITS];

  assign dp_pos = (CFG_W + 1)'(cfg.dipole_strength);
  assign dp_neg = -dp_pos;

  always_comb begin
    field_x = sel.a1_hit ? comp_out : '0;
    field_y = '0;
    case (sel.kind) inside
      KIND_COMP: begin
        field_x = comp_out;
      end
      KIND_QUAD_POS, KIND_QUAD_NEG: begin
        field_x = sat_field(SAT_IN_W'(qy));
        field_y = sat_field(SAT_IN_W'(qx));
      end
      KIND_DIP_POS: begin
        field_y = FIELD_W'(dp_pos);
      end
      KIND_DIP_NEG: begin
        field_y = FIELD_W'(dp_neg);
      end
      default: begin
        field_y = '0;
      end
    endcase
  end

endmodule

### hdl/beamline_magnet_field_lookup_core.sv
`timescale 1ns / 1ps
// Top level of the beam-line magnet field lookup: input stage, lookup logic, result stage.
//
//  channel | direction | payload                                   | transfer when
//  --------+-----------+-------------------------------------------+---------------------------
//  in_     | slave     | pos_x, pos_y, pos_z (in_tdata, 56 bits)   | in_tvalid && in_tready
//  out_    | master    | field_x, field_y (out_tdata, 48 bits)     | out_tvalid && out_tready
//  cfg_    | write     | register index cfg_addr, value cfg_wdata  | cfg_we
//
// Flow: one point per cycle while the result side keeps taking results; a point is held in the
// input register, passes region decode and field logic, and is then registered in the result
// register, from which it transfers.
// Reset: rst_n is synchronous, active low; it empties both stages and loads the register
// defaults (all zero, dipole scale 1.0).
// Stalls: both stages advance together whenever the result register is empty or being taken,
// and the input side keeps taking points while a finished result waits, as long as the input
// register is free.
module beamline_magnet_field_lookup_core #(
  parameter int POSITION_FRAC_BITS = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: pos_x [15:0], pos_y [31:16], pos_z [52:32], zero [55:53]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [55:0]                      in_tdata,
  // out_tdata: field_x [21:0], field_y [43:22], zero [47:44]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [47:0]                      out_tdata,
  input  logic                             cfg_we,
  input  logic [bmfl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bmfl_pkg::CFG_W-1:0]       cfg_wdata
);
  import bmfl_pkg::*;

  bmfl_cfg_t cfg;
  bmfl_sel_t sel;

  logic                      stage_en;
  logic                      in_xfer;

  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  logic signed [POS_W-1:0]   s1_x_r;
  logic signed [POS_W-1:0]   s1_y_r;
  logic signed [Z_W-1:0]     s1_z_r;

  logic signed [FIELD_W-1:0] fx;
  logic signed [FIELD_W-1:0] fy;

  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic signed [FIELD_W-1:0] out_fx_r;
  logic signed [FIELD_W-1:0] out_fy_r;

  bmfl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the whole pipe when the result register is free or being drained.
  assign stage_en  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || stage_en;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (stage_en) begin
      out_valid_nxt = s1_valid_r;
    end
    if (in_tready) begin
      s1_valid_nxt = in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the point in the input register until the lookup result moves on.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_r <= in_tdata[POS_W-1:0];
      s1_y_r <= in_tdata[2*POS_W-1:POS_W];
      s1_z_r <= in_tdata[2*POS_W+Z_W-1:2*POS_W];
    end
  end

  bmfl_region #(
    .FRAC_BITS (POSITION_FRAC_BITS)
  ) u_region (
    .pos_x (s1_x_r),
    .pos_y (s1_y_r),
    .pos_z (s1_z_r),
    .sel   (sel)
  );

  bmfl_field #(
    .FRAC_BITS (POSITION_FRAC_BITS)
  ) u_field (
    .cfg     (cfg),
    .sel     (sel),
    .pos_x   (s1_x_r),
    .pos_y   (s1_y_r),
    .field_x (fx),
    .field_y (fy)
  );

  always_ff @(posedge clk) begin
    if (stage_en && s1_valid_r) begin
      out_fx_r <= fx;
      out_fy_r <= fy;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_fy_r, out_fx_r};

  // A point sitting in the input register lands in the result register on the next advance.
  a_s1_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && stage_en |=> out_tvalid)
    else $error("input stage item did not reach the result register");

  // The first side A compensator belongs to side A only.
  a_a1_side : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (!sel.a1_hit || sel.side_a))
    else $error("side A compensator hit on side C");

  // A point outside every magnet gives a zero field.
  a_zero_outside : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && stage_en && (sel.kind == KIND_NONE) && !sel.a1_hit
      |=> (out_tdata == '0))
    else $error("nonzero field outside all magnets");

  // After reset no result is offered.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule
